// ===== rtl/ip4_pkg.sv =====
// Shared types, mode codes and rounding filters for the 4x4 luma intra predictor.
`default_nettype none

package ip4_pkg;

    // Prediction modes in standard numbering
    typedef enum logic [3:0] {
        MODE_VERT  = 4'd0,
        MODE_HORZ  = 4'd1,
        MODE_DC    = 4'd2,
        MODE_DDL   = 4'd3,
        MODE_DDR   = 4'd4,
        MODE_VR    = 4'd5,
        MODE_HD    = 4'd6,
        MODE_VL    = 4'd7,
        MODE_HU    = 4'd8
    } mode_t;

    localparam logic [7:0] DC_DEFAULT = 8'h80;

    // One classified block job: index 0 of both edges is the corner pixel
    typedef struct packed {
        mode_t             mode;
        logic [8:0][7:0]   tp;
        logic [4:0][7:0]   lf;
        logic [7:0]        dc;
    } ip4_job_t;

    // Rounded 2-tap filter (a+b+1)>>1
    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    // Rounded 3-tap filter (a+2b+c+2)>>2
    function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
        return s[9:2];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/intra_pred_4x4_luma.sv =====
// Top level of the 4x4 luma intra predictor: front end, job queue and row generator.
//
// Input side is a queue write port: a request word is taken at a clock edge with push
// high and full low. It carries the mode, eight top pixels, four left pixels, the
// corner pixel and three availability flags.
// Output side is a queue read port: while empty is low the oldest row word is on
// row_index, row_pixels and last_row, and it is taken at an edge with pop high.
// Every request gives four row words, top row first; last_row marks the fourth.
// When the block is idle, a taken request is written into the job queue and its first row
// is then registered in the output register. Throughput: one row word per cycle while the
// receiver pops, set by the single row generator that makes one row per cycle.
// A two-entry job queue holds the request whose rows are being made plus one more,
// so push keeps being accepted while rows of an earlier request are still drained.
// When the receiver stalls, the row register holds its word and the queue fills;
// full rises once both entries are taken. Reset empties the queue and the output
// register; no request or row survives it.
`default_nettype none

module intra_pred_4x4_luma (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [3:0]   req_type,
    input  wire logic [63:0]  top_pixels,
    input  wire logic [31:0]  left_pixels,
    input  wire logic [7:0]   corner_pixel,
    input  wire logic         left_available,
    input  wire logic         top_available,
    input  wire logic         top_right_available,
    output logic              empty,
    input  wire logic         pop,
    output logic [1:0]        row_index,
    output logic [31:0]       row_pixels,
    output logic              last_row
);
    import ip4_pkg::*;

    ip4_job_t in_job;
    ip4_job_t head_job;
    logic     q_empty;
    logic     q_pop;

    // Classify the incoming request
    ip4_front u_front (
        .req_type            (req_type),
        .top_pixels          (top_pixels),
        .left_pixels         (left_pixels),
        .corner_pixel        (corner_pixel),
        .left_available      (left_available),
        .top_available       (top_available),
        .top_right_available (top_right_available),
        .job                 (in_job)
    );

    // Decoupling queue
    ip4_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_job (in_job),
        .full   (full),
        .rd_en  (q_pop),
        .rd_job (head_job),
        .empty  (q_empty)
    );

    // Row generation
    ip4_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .job_empty  (q_empty),
        .job_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .row_index  (row_index),
        .row_pixels (row_pixels),
        .last_row   (last_row)
    );

endmodule

`default_nettype wire

// ===== rtl/ip4_front.sv =====
// Front end: unpacks a request, fixes up the top-right edge, normalises the mode, works out DC.
`default_nettype none

module ip4_front (
    input  wire logic [3:0]      req_type,
    input  wire logic [63:0]     top_pixels,
    input  wire logic [31:0]     left_pixels,
    input  wire logic [7:0]      corner_pixel,
    input  wire logic            left_available,
    input  wire logic            top_available,
    input  wire logic            top_right_available,
    output ip4_pkg::ip4_job_t    job
);
    import ip4_pkg::*;

    logic [9:0]  sum_top;
    logic [9:0]  sum_left;
    logic [10:0] sum_both;

    // Edge sums for DC
    always_comb
    begin
        sum_top  = 10'(top_pixels[7:0]) + 10'(top_pixels[15:8])
                 + 10'(top_pixels[23:16]) + 10'(top_pixels[31:24]);
        sum_left = 10'(left_pixels[7:0]) + 10'(left_pixels[15:8])
                 + 10'(left_pixels[23:16]) + 10'(left_pixels[31:24]);
        sum_both = {1'b0, sum_top} + {1'b0, sum_left} + 11'd4;
    end

    // Build the job word
    always_comb
    begin
        job.tp[0] = corner_pixel;
        job.lf[0] = corner_pixel;
        for (int i = 0; i < 4; i++)
        begin
            job.tp[i + 1] = top_pixels[8*i +: 8];
            job.lf[i + 1] = left_pixels[8*i +: 8];
        end
        // missing top-right repeats t3
        for (int i = 4; i < 8; i++)
        begin
            job.tp[i + 1] = top_right_available ? top_pixels[8*i +: 8] : top_pixels[31:24];
        end

        // codes past horizontal-up fall back to DC
        if (req_type > 4'(MODE_HU))
            job.mode = MODE_DC;
        else
            job.mode = mode_t'(req_type);

        priority if (left_available && top_available)
            job.dc = sum_both[10:3];
        else if (left_available)
            job.dc = 8'((sum_left + 10'd2) >> 2);
        else if (top_available)
            job.dc = 8'((sum_top + 10'd2) >> 2);
        else
            job.dc = DC_DEFAULT;
    end

endmodule

`default_nettype wire

// ===== rtl/ip4_queue.sv =====
// Two-entry job queue between the front end and the row generator.
`default_nettype none

module ip4_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire ip4_pkg::ip4_job_t wr_job,
    output logic                 full,
    input  wire logic            rd_en,
    output ip4_pkg::ip4_job_t    rd_job,
    output logic                 empty
);
    import ip4_pkg::*;

    ip4_job_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full   = count_reg == 2'd2;
    assign empty  = count_reg == 2'd0;
    assign rd_job = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

// ===== rtl/ip4_back.sv =====
// Back end: turns the head job into four predicted rows, one per cycle unless stalled, into an output register.
`default_nettype none

module ip4_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ip4_pkg::ip4_job_t job,
    input  wire logic            job_empty,
    output logic                 job_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [1:0]           row_index,
    output logic [31:0]          row_pixels,
    output logic                 last_row
);
    import ip4_pkg::*;

    logic [1:0]  row_reg, row_next;
    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg;
    logic [31:0] pix_reg;
    logic        last_reg;
    logic        advance;
    logic [31:0] row_pred;

    // One predicted pixel at column x of row y
    function automatic logic [7:0] pred_pixel(input ip4_job_t j, input int x, input int y);
        int z;
        int k;
        logic [7:0] v;
        v = j.dc;
        unique case (j.mode)
            MODE_VERT: v = j.tp[4'(x + 1)];
            MODE_HORZ: v = j.lf[3'(y + 1)];
            MODE_DC:   v = j.dc;
            MODE_DDL:
            begin
                if (x == 3 && y == 3)
                    v = avg3(j.tp[7], j.tp[8], j.tp[8]);
                else
                    v = avg3(j.tp[4'(x + y + 1)], j.tp[4'(x + y + 2)], j.tp[4'(x + y + 3)]);
            end
            MODE_DDR:
            begin
                k = x - y;
                priority if (k > 0)
                    v = avg3(j.tp[4'(k - 1)], j.tp[4'(k)], j.tp[4'(k + 1)]);
                else if (k < 0)
                    v = avg3(j.lf[3'(-k - 1)], j.lf[3'(-k)], j.lf[3'(-k + 1)]);
                else
                    v = avg3(j.tp[1], j.tp[0], j.lf[1]);
            end
            MODE_VR:
            begin
                z = 2 * x - y;
                k = x - (y >> 1);
                priority if (z >= 0 && (z & 1) == 0)
                    v = avg2(j.tp[4'(k)], j.tp[4'(k + 1)]);
                else if (z > 0)
                    v = avg3(j.tp[4'(k - 1)], j.tp[4'(k)], j.tp[4'(k + 1)]);
                else if (z == -1)
                    v = avg3(j.lf[1], j.tp[0], j.tp[1]);
                else
                    v = avg3(j.lf[3'(y)], j.lf[3'(y - 1)], j.lf[3'(y - 2)]);
            end
            MODE_HD:
            begin
                z = 2 * y - x;
                k = y - (x >> 1);
                priority if (z >= 0 && (z & 1) == 0)
                    v = avg2(j.lf[3'(k)], j.lf[3'(k + 1)]);
                else if (z > 0)
                    v = avg3(j.lf[3'(k - 1)], j.lf[3'(k)], j.lf[3'(k + 1)]);
                else if (z == -1)
                    v = avg3(j.lf[1], j.tp[0], j.tp[1]);
                else
                    v = avg3(j.tp[4'(x)], j.tp[4'(x - 1)], j.tp[4'(x - 2)]);
            end
            MODE_VL:
            begin
                k = x + (y >> 1);
                if ((y & 1) == 0)
                    v = avg2(j.tp[4'(k + 1)], j.tp[4'(k + 2)]);
                else
                    v = avg3(j.tp[4'(k + 1)], j.tp[4'(k + 2)], j.tp[4'(k + 3)]);
            end
            MODE_HU:
            begin
                z = x + 2 * y;
                k = y + (x >> 1);
                priority if (z > 5)
                    v = j.lf[4];
                else if (z == 5)
                    v = avg3(j.lf[3], j.lf[4], j.lf[4]);
                else if ((z & 1) == 0)
                    v = avg2(j.lf[3'(k + 1)], j.lf[3'(k + 2)]);
                else
                    v = avg3(j.lf[3'(k + 1)], j.lf[3'(k + 2)], j.lf[3'(k + 3)]);
            end
            default: v = j.dc;
        endcase
        return v;
    endfunction

    // Four column lanes for the current row
    always_comb
    begin
        for (int x = 0; x < 4; x++)
            row_pred[8*x +: 8] = pred_pixel(job, x, int'(row_reg));
    end

    // Move a row into the output register whenever a job is queued and the register is free or being drained
    assign advance    = !job_empty && (!valid_reg || pop);
    assign job_pop    = advance && (row_reg == 2'd3);
    assign empty      = !valid_reg;
    assign row_index  = idx_reg;
    assign row_pixels = pix_reg;
    assign last_row   = last_reg;

    always_comb
    begin
        row_next   = advance ? row_reg + 2'd1 : row_reg;
        valid_next = advance || (valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg  <= row_reg;
            pix_reg  <= row_pred;
            last_reg <= row_reg == 2'd3;
        end
    end

endmodule

`default_nettype wire

// ===== bench/intra_pred_4x4_luma_tb.sv =====
// Self-checking bench for the 4x4 luma intra predictor: directed table, random bursts, row checks.
module intra_pred_4x4_luma_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ip4_pkg::*;

    // Modes outside the standard nine fall back to DC
    localparam logic [3:0] MODE_UNDEF_LO = 4'd9;
    localparam logic [3:0] MODE_UNDEF_HI = 4'd15;

    localparam int DIR_COUNT     = 22;
    localparam int RANDOM_BLOCKS = 146;
    localparam int HOLD_CYCLES   = 48;
    localparam int BURST_MAX     = 16;

    // One block request; typed_in marks a row value written straight into the table
    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] top;
        logic [31:0] left;
        logic [7:0]  corner;
        logic        la;
        logic        ta;
        logic        tra;
        logic        typed_in;
        logic [31:0] typed_row;
    } block_req_t;

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] pix;
        logic        last;
    } row_word_t;

    typedef enum logic [1:0] {
        TAKE_ALL,
        TAKE_COIN,
        TAKE_PATTERN
    } take_style_t;

    // Fields: mode, top t7..t0, left l3..l0, corner, left/top/top-right flags, typed_in flag, typed row
    localparam block_req_t DIR_TAB [DIR_COUNT] = '{
        // neither edge for DC gives mid-grey
        '{MODE_DC,   64'h0123_4567_89AB_CDEF, 32'hFEDC_BA98, 8'h5A,
          1'b0, 1'b0, 1'b1, 1'b1, 32'h8080_8080},
        '{MODE_VERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{MODE_HORZ, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 8'hFF,
          1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{MODE_DC,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
          1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{MODE_DC,   64'h0000_0000_0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 1'b0, 1'b1, 32'h0000_0000},
        // DC with each single edge, then both
        '{MODE_DC,   64'h8877_6655_4433_2211, 32'h1F3C_5A78, 8'hA5,
          1'b1, 1'b0, 1'b1, 1'b0, 32'h0},
        '{MODE_DC,   64'h8877_6655_4433_2211, 32'h1F3C_5A78, 8'hA5,
          1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
        '{MODE_DC,   64'hF0E1_D2C3_B4A5_9687, 32'h0718_293A, 8'h4B,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        // every directional mode
        '{MODE_VERT, 64'hF0E1_D2C3_B4A5_9687, 32'h0718_293A, 8'h4B,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_HORZ, 64'hF0E1_D2C3_B4A5_9687, 32'h0718_293A, 8'h4B,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_DDL,  64'hF0E1_D2C3_B4A5_9687, 32'h0718_293A, 8'h4B,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        // top-right missing: t4..t7 follow t3
        '{MODE_DDL,  64'hF0E1_D2C3_B4A5_9687, 32'h0718_293A, 8'h4B,
          1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{MODE_DDR,  64'h8877_6655_4433_2211, 32'h1F3C_5A78, 8'hA5,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_VR,   64'h8877_6655_4433_2211, 32'h1F3C_5A78, 8'hA5,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_HD,   64'h8877_6655_4433_2211, 32'h1F3C_5A78, 8'hA5,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_VL,   64'h3C96_E1A7_52F0_0D4E, 32'hC3B2_A190, 8'h7F,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_VL,   64'h3C96_E1A7_52F0_0D4E, 32'hC3B2_A190, 8'h7F,
          1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{MODE_HU,   64'h3C96_E1A7_52F0_0D4E, 32'hC3B2_A190, 8'h7F,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        // unknown modes behave as DC
        '{MODE_UNDEF_LO, 64'h3C96_E1A7_52F0_0D4E, 32'hC3B2_A190, 8'h7F,
          1'b0, 1'b0, 1'b0, 1'b1, 32'h8080_8080},
        '{MODE_UNDEF_HI, 64'h3C96_E1A7_52F0_0D4E, 32'hC3B2_A190, 8'h7F,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        // rails on opposite edges
        '{MODE_DDR,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 8'hFF,
          1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
        '{MODE_VR,   64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 8'h00,
          1'b0, 1'b0, 1'b0, 1'b0, 32'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [3:0]  req_type;
    logic [63:0] top_pixels;
    logic [31:0] left_pixels;
    logic [7:0]  corner_pixel;
    logic        left_available;
    logic        top_available;
    logic        top_right_available;
    logic        empty;
    logic        pop;
    logic [1:0]  row_index;
    logic [31:0] row_pixels;
    logic        last_row;

    row_word_t rows_due [$];
    int        errors = 0;
    bit        hold_req = 1'b0;

    intra_pred_4x4_luma dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .req_type            (req_type),
        .top_pixels          (top_pixels),
        .left_pixels         (left_pixels),
        .corner_pixel        (corner_pixel),
        .left_available      (left_available),
        .top_available       (top_available),
        .top_right_available (top_right_available),
        .empty               (empty),
        .pop                 (pop),
        .row_index           (row_index),
        .row_pixels          (row_pixels),
        .last_row            (last_row)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Rounded two- and three-tap filters
    function automatic int tap2(input int a, input int b);
        return (a + b + 1) >> 1;
    endfunction

    function automatic int tap3(input int a, input int b, input int c);
        return (a + 2 * b + c + 2) >> 2;
    endfunction

    // Predicted block, one packed row per entry, column 0 in the low byte
    function automatic logic [3:0][31:0] predict_block(input block_req_t r);
        int tp [9];
        int lf [5];
        int st;
        int sl;
        int v;
        int z;
        int k;
        logic [3:0] m;
        logic [3:0][31:0] rows;
        tp[0] = r.corner;
        lf[0] = r.corner;
        for (int i = 0; i < 8; i++)
            tp[i + 1] = r.top[8 * i +: 8];
        for (int i = 0; i < 4; i++)
            lf[i + 1] = r.left[8 * i +: 8];
        // no top-right: t3 is copied outward
        if (!r.tra)
            for (int i = 5; i < 9; i++)
                tp[i] = tp[4];
        m = (r.mode > MODE_HU) ? MODE_DC : r.mode;
        st = tp[1] + tp[2] + tp[3] + tp[4];
        sl = lf[1] + lf[2] + lf[3] + lf[4];
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                v = 0;
                case (m)
                    MODE_VERT: v = tp[x + 1];
                    MODE_HORZ: v = lf[y + 1];
                    MODE_DC:
                    begin
                        if (r.la && r.ta)
                            v = (st + sl + 4) >> 3;
                        else if (r.la)
                            v = (sl + 2) >> 2;
                        else if (r.ta)
                            v = (st + 2) >> 2;
                        else
                            v = 128;
                    end
                    MODE_DDL:
                    begin
                        if (x == 3 && y == 3)
                            v = tap3(tp[7], tp[8], tp[8]);
                        else
                            v = tap3(tp[x + y + 1], tp[x + y + 2], tp[x + y + 3]);
                    end
                    MODE_DDR:
                    begin
                        k = x - y;
                        if (k > 0)
                            v = tap3(tp[k - 1], tp[k], tp[k + 1]);
                        else if (k < 0)
                            v = tap3(lf[-k - 1], lf[-k], lf[-k + 1]);
                        else
                            v = tap3(tp[1], r.corner, lf[1]);
                    end
                    MODE_VR:
                    begin
                        z = 2 * x - y;
                        k = x - (y >> 1);
                        if (z >= 0 && (z % 2) == 0)
                            v = tap2(tp[k], tp[k + 1]);
                        else if (z > 0)
                            v = tap3(tp[k - 1], tp[k], tp[k + 1]);
                        else if (z == -1)
                            v = tap3(lf[1], r.corner, tp[1]);
                        else
                            v = tap3(lf[y], lf[y - 1], lf[y - 2]);
                    end
                    MODE_HD:
                    begin
                        z = 2 * y - x;
                        k = y - (x >> 1);
                        if (z >= 0 && (z % 2) == 0)
                            v = tap2(lf[k], lf[k + 1]);
                        else if (z > 0)
                            v = tap3(lf[k - 1], lf[k], lf[k + 1]);
                        else if (z == -1)
                            v = tap3(lf[1], r.corner, tp[1]);
                        else
                            v = tap3(tp[x], tp[x - 1], tp[x - 2]);
                    end
                    MODE_VL:
                    begin
                        k = x + (y >> 1);
                        if ((y % 2) == 0)
                            v = tap2(tp[k + 1], tp[k + 2]);
                        else
                            v = tap3(tp[k + 1], tp[k + 2], tp[k + 3]);
                    end
                    MODE_HU:
                    begin
                        z = x + 2 * y;
                        k = y + (x >> 1);
                        if (z > 5)
                            v = lf[4];
                        else if (z == 5)
                            v = tap3(lf[3], lf[4], lf[4]);
                        else if ((z % 2) == 0)
                            v = tap2(lf[k + 1], lf[k + 2]);
                        else
                            v = tap3(lf[k + 1], lf[k + 2], lf[k + 3]);
                    end
                    default: v = 0;
                endcase
                rows[y][8 * x +: 8] = v[7:0];
            end
        end
        return rows;
    endfunction

    // Random request; some bytes pushed to the rails
    function automatic block_req_t random_block();
        block_req_t r;
        if ($urandom_range(0, 15) == 0)
            r.mode = 4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
        else
            r.mode = 4'($urandom_range(MODE_VERT, MODE_HU));
        r.top    = {$urandom, $urandom};
        r.left   = $urandom;
        r.corner = 8'($urandom);
        for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 5) == 0)
                r.top[8 * i +: 8] = {8{1'($urandom_range(0, 1))}};
        for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 5) == 0)
                r.left[8 * i +: 8] = {8{1'($urandom_range(0, 1))}};
        if ($urandom_range(0, 5) == 0)
            r.corner = {8{1'($urandom_range(0, 1))}};
        r.la        = 1'($urandom_range(0, 1));
        r.ta        = 1'($urandom_range(0, 1));
        r.tra       = 1'($urandom_range(0, 1));
        r.typed_in  = 1'b0;
        r.typed_row = '0;
        return r;
    endfunction

    // Offer one request from a falling edge; on acceptance queue its four row words
    task automatic send_block(input block_req_t r);
        logic [3:0][31:0] rows;
        push                <= 1'b1;
        req_type            <= r.mode;
        top_pixels          <= r.top;
        left_pixels         <= r.left;
        corner_pixel        <= r.corner;
        left_available      <= r.la;
        top_available       <= r.ta;
        top_right_available <= r.tra;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rows = r.typed_in ? {4{r.typed_row}} : predict_block(r);
        for (int y = 0; y < 4; y++)
            rows_due.push_back(row_word_t'{2'(y), rows[y], y == 3});
        @(negedge clk);
    endtask

    task automatic idle_input(input int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (rows_due.size() != 0)
            @(negedge clk);
    endtask

    // Request side
    initial
    begin : request_feed
        int burst;
        rst_n               = 1'b0;
        push                = 1'b0;
        req_type            = '0;
        top_pixels          = '0;
        left_pixels         = '0;
        corner_pixel        = '0;
        left_available      = 1'b0;
        top_available       = 1'b0;
        top_right_available = 1'b0;
        burst               = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (DIR_TAB[i])
        begin
            send_block(DIR_TAB[i]);
            idle_input($urandom_range(0, 3));
        end

        // sender stops until every row word is back
        idle_input(1);
        wait_drained();

        // long receiver hold-off with requests back to back: queue fills, full rises
        hold_req = 1'b1;
        repeat (12) send_block(random_block());

        // random bursts with gaps, one full drain half way
        for (int n = 0; n < RANDOM_BLOCKS; n++)
        begin
            send_block(random_block());
            if (n == RANDOM_BLOCKS / 2)
            begin
                idle_input(1);
                wait_drained();
            end
            else if (burst == 0)
            begin
                burst = $urandom_range(1, BURST_MAX);
                idle_input($urandom_range(1, 6));
            end
            else
                burst--;
        end
        idle_input(1);

        // drain, then a short quiet spell to catch stray words
        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Row side: own stall pattern, plus the long hold-off on request
    initial
    begin : row_sink
        take_style_t style;
        logic [15:0] pat;
        int          style_left;
        int          hold_left;
        int          cyc;
        row_word_t   exp_w;
        pop        = 1'b0;
        style      = TAKE_ALL;
        pat        = '1;
        style_left = 0;
        hold_left  = 0;
        cyc        = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (style_left == 0)
            begin
                style      = take_style_t'($urandom_range(TAKE_ALL, TAKE_PATTERN));
                pat        = 16'($urandom) | 16'h0001;
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (style)
                    TAKE_ALL:  pop <= 1'b1;
                    TAKE_COIN: pop <= 1'($urandom_range(0, 1));
                    default:   pop <= pat[cyc % 16];
                endcase
            end

            // check the word taken at this edge
            @(posedge clk);
            if (pop && !empty)
            begin
                if (rows_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected row word: index %0d pixels %h last %b",
                             $time, row_index, row_pixels, last_row);
                end
                else
                begin
                    exp_w = rows_due.pop_front();
                    if (row_index !== exp_w.idx)
                    begin
                        errors++;
                        $display("%0t: row_index expected %0d actual %0d",
                                 $time, exp_w.idx, row_index);
                    end
                    if (row_pixels !== exp_w.pix)
                    begin
                        errors++;
                        $display("%0t: row_pixels (row %0d) expected %h actual %h",
                                 $time, exp_w.idx, exp_w.pix, row_pixels);
                    end
                    if (last_row !== exp_w.last)
                    begin
                        errors++;
                        $display("%0t: last_row (row %0d) expected %b actual %b",
                                 $time, exp_w.idx, exp_w.last, last_row);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
